// ===== design/sud_pkg.sv =====
// ============================================================================
// sud_pkg
// Shared constants, types and helpers of the pipelined integer divider.
// ============================================================================
`default_nettype none

package sud_pkg;

    // Working word width of the divider.
    localparam int DATA_WIDTH = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W   = 2;
    localparam int FIELD_W = 32;

    // Operation codes.
    localparam logic [CMD_W-1:0] CMD_DIV  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DIVU = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REM  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMU = 2'd3;

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam word_t WORD_ONES = {DATA_WIDTH{1'b1}};
    localparam word_t WORD_SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Item state as it travels down the pipeline.
    typedef struct packed {
        logic  want_rem;  // deliver remainder rather than quotient
        logic  neg;       // negate the delivered result
        logic  special;   // divide by zero or signed overflow
        word_t spec;      // result for the special cases
        word_t mb;        // divisor magnitude
        word_t r;         // partial remainder
        word_t aq;        // dividend bits still to use, quotient bits filling in
    } work_t;

    // Field word to working word: low bits kept, zero-extended if wider.
    function automatic word_t to_word(input logic [FIELD_W-1:0] x);
        logic [63:0] x64;
        x64 = {32'b0, x};
        return x64[DATA_WIDTH-1:0];
    endfunction

    // Working word to field word.
    function automatic logic [FIELD_W-1:0] from_word(input word_t w);
        logic [63:0] w64;
        w64 = 64'(w);
        return w64[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/sud_req_if.sv =====
// ============================================================================
// sud_req_if
// Request channel: operation and operand words.
// ============================================================================
`default_nettype none

interface sud_req_if;
    logic                         valid;
    logic                         ready;
    logic [sud_pkg::CMD_W-1:0]    cmd;
    logic [sud_pkg::FIELD_W-1:0]  dividend;
    logic [sud_pkg::FIELD_W-1:0]  divisor;

    modport source (output valid, cmd, dividend, divisor, input ready);
    modport sink   (input valid, cmd, dividend, divisor, output ready);
endinterface

`default_nettype wire

// ===== design/sud_rsp_if.sv =====
// ============================================================================
// sud_rsp_if
// Response channel: one result word per beat.
// ============================================================================
`default_nettype none

interface sud_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sud_pkg::FIELD_W-1:0]  result_word;

    modport source (output valid, result_word, input ready);
    modport sink   (input valid, result_word, output ready);
endinterface

`default_nettype wire

// ===== design/sud_pre.sv =====
// ============================================================================
// sud_pre
// Entry stage: operand magnitudes, sign handling and special cases.
// ============================================================================
`default_nettype none

module sud_pre (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sud_req_if.sink          req,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output sud_pkg::work_t   dn_data
);
    import sud_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    word_t a;
    word_t b;
    logic  is_signed;
    logic  want_rem;
    logic  an;
    logic  bn;

    assign req.ready = !valid_reg || dn_ready;

    always_comb
    begin
        a         = to_word(req.dividend);
        b         = to_word(req.divisor);
        is_signed = (req.cmd == CMD_DIV) || (req.cmd == CMD_REM);
        want_rem  = (req.cmd == CMD_REM) || (req.cmd == CMD_REMU);
        an        = is_signed && a[DATA_WIDTH-1];
        bn        = is_signed && b[DATA_WIDTH-1];

        data_next.want_rem = want_rem;
        data_next.neg      = want_rem ? an : (an != bn);
        data_next.mb       = bn ? (~b + 1'b1) : b;
        data_next.aq       = an ? (~a + 1'b1) : a;
        data_next.r        = '0;
        data_next.special  = 1'b0;
        data_next.spec     = '0;

        if (b == '0)
        begin
            data_next.special = 1'b1;
            data_next.spec    = want_rem ? a : WORD_ONES;
        end
        else if (is_signed && (a == WORD_SIGN) && (b == WORD_ONES))
        begin
            data_next.special = 1'b1;
            data_next.spec    = want_rem ? '0 : WORD_SIGN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/sud_step.sv =====
// ============================================================================
// sud_step
// One restoring shift-and-subtract step: yields one quotient bit.
// ============================================================================
`default_nettype none

module sud_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire sud_pkg::work_t   up_data,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output sud_pkg::work_t        dn_data
);
    import sud_pkg::*;

    logic              valid_reg;
    work_t             data_reg;
    work_t             data_next;
    logic [DATA_WIDTH:0] r_wide;
    logic [DATA_WIDTH:0] diff;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        // Partial remainder shifted up with the next dividend bit.
        r_wide    = {up_data.r, up_data.aq[DATA_WIDTH-1]};
        diff      = r_wide - {1'b0, up_data.mb};
        data_next = up_data;
        if (!diff[DATA_WIDTH])
        begin
            data_next.r = diff[DATA_WIDTH-1:0];
        end
        else
        begin
            data_next.r = r_wide[DATA_WIDTH-1:0];
        end
        data_next.aq = {up_data.aq[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

`ifndef NO_ASSERTIONS
    // Restoring division keeps the partial remainder below the divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_reg.special) |-> (data_reg.r < data_reg.mb))
        else $error("sud_step: partial remainder not below divisor");

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dn_ready) |=> valid_reg)
        else $error("sud_step: beat lost during stall");

    a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dn_ready) |=> $stable(data_reg))
        else $error("sud_step: stalled beat changed");
`endif

endmodule

`default_nettype wire

// ===== design/sud_post.sv =====
// ============================================================================
// sud_post
// Exit stage: result selection, sign fix-up and output register.
// ============================================================================
`default_nettype none

module sud_post (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire sud_pkg::work_t   up_data,
    sud_rsp_if.source             rsp
);
    import sud_pkg::*;

    logic  valid_reg;
    word_t res_reg;
    word_t res_next;
    word_t mag;

    assign up_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        // After the last step aq holds the quotient.
        mag = up_data.want_rem ? up_data.r : up_data.aq;
        if (up_data.special)
        begin
            res_next = up_data.spec;
        end
        else if (up_data.neg)
        begin
            res_next = ~mag + 1'b1;
        end
        else
        begin
            res_next = mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.result_word = from_word(res_reg);

endmodule

`default_nettype wire

// ===== design/signed_unsigned_integer_divider_unit.sv =====
// Pipelined integer divider with RISC-V M-extension semantics (div, divu,
// rem, remu). While rsp.ready stays high, one request beat may be accepted
// every cycle and one result beat leaves per cycle. The stages are:
// an entry stage for magnitudes and special cases, one restoring subtract
// stage per quotient bit, and an output stage for sign fix-up. Every stage
// holds its beat while the response side stalls, so back-pressure ripples
// back to req.ready without loss. Divide by zero returns all ones (quotient)
// or the dividend (remainder); signed overflow returns the most negative
// value with remainder zero.
// ============================================================================
// signed_unsigned_integer_divider_unit
// Top level: entry stage, bit-serial chain of subtract stages, exit stage.
// ============================================================================
`default_nettype none

module signed_unsigned_integer_divider_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sud_req_if.sink     req,
    sud_rsp_if.source   rsp
);
    import sud_pkg::*;

    logic  stg_valid [0:DATA_WIDTH];
    logic  stg_ready [0:DATA_WIDTH];
    work_t stg_data  [0:DATA_WIDTH];

    sud_pre u_pre (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_data  (stg_data[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        sud_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up_data  (stg_data[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn_data  (stg_data[i+1])
        );
    end

    sud_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[DATA_WIDTH]),
        .up_ready (stg_ready[DATA_WIDTH]),
        .up_data  (stg_data[DATA_WIDTH]),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ===== bench/tb_signed_unsigned_integer_divider_unit.sv =====
// ----------------------------------------------------------------------------
// tb_signed_unsigned_integer_divider_unit
// Self-checking bench for the pipelined divider. Requests come from a queue
// that one initial block fills, and a driver sends them. A monitor predicts
// each result as its request beat goes in. It checks every response beat in
// order against that prediction. The run has three phases of handshake
// idling, and the pipeline drains fully between phases.
// ----------------------------------------------------------------------------
module tb_signed_unsigned_integer_divider_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sud_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEMS_PER_PASS = 200;
    localparam int REPORT_MAX     = 10;

    localparam logic [FIELD_W-1:0] FIELD_MIN  = FIELD_W'(WORD_SIGN);
    localparam logic [FIELD_W-1:0] FIELD_ONES = FIELD_W'(WORD_ONES);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        div_req_t           req;
        logic [FIELD_W-1:0] result;
    } div_expect_t;

    logic clk;
    logic rst_n;

    sud_req_if req_ch ();
    sud_rsp_if rsp_ch ();

    signed_unsigned_integer_divider_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    div_req_t    pending_q[$];
    div_expect_t result_q[$];

    int   snd_idle_pct;
    int   rcv_idle_pct;
    int   mismatch_count;
    int   quiet_cycles;
    logic req_beat_taken;

    // Restoring shift-and-subtract on magnitudes, signs fixed up afterwards.
    function automatic logic [FIELD_W-1:0] divide_result(
        input logic [CMD_W-1:0]   cmd,
        input logic [FIELD_W-1:0] dividend,
        input logic [FIELD_W-1:0] divisor
    );
        word_t               a;
        word_t               b;
        word_t               ma;
        word_t               mb;
        word_t               quo;
        word_t               rem;
        logic [DATA_WIDTH:0] acc;
        logic                is_signed;
        logic                want_rem;
        logic                flip;

        a         = word_t'(dividend);
        b         = word_t'(divisor);
        is_signed = (cmd == CMD_DIV) || (cmd == CMD_REM);
        want_rem  = (cmd == CMD_REM) || (cmd == CMD_REMU);
        flip      = 1'b0;

        if (b == '0)
        begin
            quo = WORD_ONES;
            rem = a;
        end
        else if (is_signed && a == WORD_SIGN && b == WORD_ONES)
        begin
            quo = WORD_SIGN;
            rem = '0;
        end
        else
        begin
            ma = a;
            mb = b;
            if (is_signed)
            begin
                if (a[DATA_WIDTH-1])
                    ma = -a;
                if (b[DATA_WIDTH-1])
                    mb = -b;
                flip = want_rem ? a[DATA_WIDTH-1] : (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]);
            end
            acc = '0;
            quo = '0;
            for (int i = DATA_WIDTH - 1; i >= 0; i--)
            begin
                acc = {acc[DATA_WIDTH-1:0], ma[i]};
                if (acc >= {1'b0, mb})
                begin
                    acc    = acc - {1'b0, mb};
                    quo[i] = 1'b1;
                end
            end
            rem = acc[DATA_WIDTH-1:0];
            if (flip)
            begin
                quo = -quo;
                rem = -rem;
            end
        end
        return FIELD_W'(want_rem ? rem : quo);
    endfunction

    function automatic div_req_t random_div_req();
        div_req_t item;
        int       kind;

        kind          = $urandom_range(0, 9);
        item.cmd      = CMD_W'($urandom_range(0, 3));
        item.dividend = $urandom;
        item.divisor  = $urandom;
        case (kind)
            0: item.divisor = '0;
            1:
            begin
                item.dividend = FIELD_MIN;
                if ($urandom_range(0, 1) == 1)
                    item.divisor = FIELD_ONES;
            end
            2:
            begin
                item.divisor = FIELD_W'($urandom_range(1, 16));
                if ($urandom_range(0, 1) == 1)
                    item.divisor = -item.divisor;
            end
            3: item.dividend = FIELD_W'($urandom_range(0, 255));
            4: item.divisor = item.dividend >> $urandom_range(0, 31);
            5: item.divisor = item.divisor >> $urandom_range(0, 31);
            default: ;
        endcase
        return item;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: a beat is held until taken, then the next one may follow.
    always @(negedge clk)
    begin
        div_req_t nxt;

        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            if (!req_ch.valid || req_beat_taken)
            begin
                req_beat_taken = 1'b0;
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.cmd      <= nxt.cmd;
                    req_ch.dividend <= nxt.dividend;
                    req_ch.divisor  <= nxt.divisor;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        div_expect_t exp_item;
        div_expect_t head;
        logic        beat_seen;

        if (rst_n)
        begin
            beat_seen = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                exp_item.req.cmd      = req_ch.cmd;
                exp_item.req.dividend = req_ch.dividend;
                exp_item.req.divisor  = req_ch.divisor;
                exp_item.result       = divide_result(req_ch.cmd, req_ch.dividend,
                                                      req_ch.divisor);
                result_q.push_back(exp_item);
                req_beat_taken = 1'b1;
                beat_seen      = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                beat_seen = 1'b1;
                if (result_q.size() == 0)
                begin
                    note_mismatch($sformatf("result_word %h with nothing outstanding",
                                            rsp_ch.result_word));
                end
                else
                begin
                    head = result_q.pop_front();
                    if (rsp_ch.result_word !== head.result)
                        note_mismatch($sformatf(
                            "cmd %0d %h / %h: result_word exp %h got %h",
                            head.req.cmd, head.req.dividend, head.req.divisor,
                            head.result, rsp_ch.result_word));
                end
            end
            quiet_cycles = beat_seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("signed_unsigned_integer_divider_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [FIELD_W-1:0] corner_dividend [6];
        logic [FIELD_W-1:0] corner_divisor  [6];
        div_req_t           item;

        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_DIV;
        req_ch.dividend = '0;
        req_ch.divisor  = '0;
        rsp_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        req_beat_taken  = 1'b0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        snd_idle_pct    = 0;
        rcv_idle_pct    = 0;

        // divide by zero, signed overflow, mixed signs, extremes
        corner_dividend = '{FIELD_ONES, FIELD_MIN, 32'hFFFF_FFF9, 32'd7,
                            32'h7FFF_FFFF, 32'd0};
        corner_divisor  = '{32'd0, FIELD_ONES, 32'd2, 32'hFFFF_FFFE,
                            32'd1, FIELD_MIN};
        for (int k = 0; k < 6; k++)
        begin
            item.dividend = corner_dividend[k];
            item.divisor  = corner_divisor[k];
            item.cmd = CMD_DIV;
            pending_q.push_back(item);
            item.cmd = CMD_DIVU;
            pending_q.push_back(item);
            item.cmd = CMD_REM;
            pending_q.push_back(item);
            item.cmd = CMD_REMU;
            pending_q.push_back(item);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Receiver then sender idles most; last pass runs flat out.
        // Between passes the sender waits for every result.
        for (int pass = 0; pass < 3; pass++)
        begin
            snd_idle_pct = (pass == 0) ? 34 : (pass == 1) ? 66 : 0;
            rcv_idle_pct = (pass == 0) ? 66 : (pass == 1) ? 34 : 0;
            repeat (ITEMS_PER_PASS) pending_q.push_back(random_div_req());
            while (pending_q.size() != 0 || req_ch.valid || result_q.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && result_q.size() == 0)
            $display("signed_unsigned_integer_divider_unit regression: pass");
        else
            $display("signed_unsigned_integer_divider_unit regression: fail");
        $finish;
    end

endmodule
